@@ hw/rtl/etcap_pkg.sv @@
package etcap_pkg;

   localparam int MODE_W     = 2;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int TIME_W     = 32;
   localparam int PC_W       = 6;
   localparam int TMO_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_IN_US = 2'd2;

   localparam logic [PC_W-1:0]  PULSE_COUNT_RST   = 6'd1;
   localparam logic [TMO_W-1:0] TIMEOUT_VALUE_RST = 24'd1000;

   typedef struct packed {
      logic write;
      logic clear;
   } store_cmd_type;

endpackage

@@ hw/rtl/edge_timestamp_capture_core.sv @@
// Edge timestamp capture core.
// Command channel: an item (req_mode, req_pin_level, req_entry_index) is taken
// on a clock edge with start high and busy low. Modes: start arms a capture
// and its timeout, tick advances the microsecond counter and samples the pin,
// read returns the level and duration of an entry, clear empties the store.
// Response channel: every item gives one word, shown for exactly one cycle
// with rsp_valid high; it carries the read fields and the capture status
// after the item. The receiver cannot stall the core.
// Flow: start, tick and clear answer in the cycle after they are taken and
// keep busy low, so one can be issued every cycle. For a read, the store is
// read at the accept edge (synchronous read, two ports), busy is high for
// one cycle, and the word follows in the cycle after that.
// Config: csr_we/csr_index/csr_wdata write pulse_count (0), timeout_value (1)
// and timeout_in_us (2); a written value applies to items taken after the write.
// Reset: synchronous; registers return to defaults, counters and status
// clear, and the store reads as all zero with no clearing pass.
module edge_timestamp_capture_core #(
   parameter int MAX_ENTRIES  = 64,
   parameter int TICKS_PER_MS = 1000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [etcap_pkg::MODE_W-1:0]     req_mode,
   input  logic                             req_pin_level,
   input  logic [etcap_pkg::IDX_W-1:0]      req_entry_index,
   input  logic                             csr_we,
   input  logic [etcap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [etcap_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_level_at_index,
   output logic                             rsp_level_valid,
   output logic [etcap_pkg::TIME_W-1:0]     rsp_pulse_span,
   output logic                             rsp_duration_valid,
   output logic signed [etcap_pkg::CNT_W-1:0] rsp_sequence_length,
   output logic                             rsp_capturing,
   output logic                             rsp_completed,
   output logic                             rsp_timed_out
);
   import etcap_pkg::*;

   localparam int SUB_W   = $clog2(TICKS_PER_MS + 1);
   localparam int ELAP_W  = TMO_W + 1;
   localparam int CAP_INT = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;
   localparam logic [CNT_W-1:0] HELD_CAP = CNT_W'(CAP_INT);
   localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_MS - 1);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type          state_ff, state_in;
   logic [PC_W-1:0]    pulse_count_ff, pulse_count_in;
   logic [TMO_W-1:0]   timeout_value_ff, timeout_value_in;
   logic               timeout_in_us_ff, timeout_in_us_in;
   logic [CNT_W-1:0]   rec_ff, rec_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [ELAP_W-1:0]  us_ff, us_in, us_next;
   logic [ELAP_W-1:0]  ms_ff, ms_in, ms_next;
   logic [SUB_W-1:0]   sub_ff, sub_in, sub_next;
   logic               running_ff, running_in;
   logic               done_ff, done_in;
   logic               tmo_ff, tmo_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_lvl_ff, rsp_lvl_in;
   logic               rsp_lvl_ok_ff, rsp_lvl_ok_in;
   logic [TIME_W-1:0]  rsp_dur_ff, rsp_dur_in;
   logic               rsp_dur_ok_ff, rsp_dur_ok_in;
   logic [CNT_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic               rsp_cap_ff, rsp_cap_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_tmo_ff, rsp_tmo_in;

   mode_type           mode;
   logic               accept;
   logic [CNT_W-1:0]   pc_plus, held;
   logic [CNT_W-1:0]   idx_ext, idx_next;
   logic               tmo_hit;
   store_cmd_type      cmd;
   logic [CNT_W-1:0]   rd_addr0, rd_addr1;
   logic               rd_level0;
   logic [TIME_W-1:0]  rd_time0, rd_time1;

   assign mode    = mode_type'(req_mode);
   assign busy    = state_ff == ST_READ;
   assign accept  = start && !busy;
   assign pc_plus = CNT_W'(pulse_count_ff) + CNT_W'(1);
   assign held    = (pc_plus > HELD_CAP) ? HELD_CAP : pc_plus;
   assign idx_ext = CNT_W'(idx_ff);
   assign idx_next = idx_ext + CNT_W'(1);
   assign rd_addr0 = CNT_W'(req_entry_index);
   assign rd_addr1 = CNT_W'(req_entry_index) + CNT_W'(1);

   // timeout counters; microsecond and millisecond counts saturate past 24 bits
   always_comb begin
      us_next  = us_ff[ELAP_W-1] ? us_ff : us_ff + ELAP_W'(1);
      sub_next = sub_ff + SUB_W'(1);
      ms_next  = ms_ff;
      if (sub_ff == SUB_LAST) begin
         sub_next = '0;
         ms_next  = ms_ff[ELAP_W-1] ? ms_ff : ms_ff + ELAP_W'(1);
      end
      tmo_hit = timeout_in_us_ff ? (us_next >= ELAP_W'(timeout_value_ff))
                                 : (ms_next >= ELAP_W'(timeout_value_ff));
   end

   always_comb begin
      state_in         = state_ff;
      pulse_count_in   = pulse_count_ff;
      timeout_value_in = timeout_value_ff;
      timeout_in_us_in = timeout_in_us_ff;
      rec_in           = rec_ff;
      time_in          = time_ff;
      us_in            = us_ff;
      ms_in            = ms_ff;
      sub_in           = sub_ff;
      running_in       = running_ff;
      done_in          = done_ff;
      tmo_in           = tmo_ff;
      last_in          = last_ff;
      idx_in           = idx_ff;
      cmd              = '0;
      rsp_valid_in     = 1'b0;
      rsp_lvl_in       = 1'b0;
      rsp_lvl_ok_in    = 1'b0;
      rsp_dur_in       = '0;
      rsp_dur_ok_in    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE_COUNT:   pulse_count_in   = csr_wdata[PC_W-1:0];
            CSR_TIMEOUT_VALUE: timeout_value_in = csr_wdata[TMO_W-1:0];
            CSR_TIMEOUT_IN_US: timeout_in_us_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (mode)
                  MODE_START: begin
                     rec_in     = '0;
                     us_in      = '0;
                     ms_in      = '0;
                     sub_in     = '0;
                     running_in = 1'b1;
                     done_in    = 1'b0;
                     tmo_in     = 1'b0;
                  end
                  MODE_TICK: begin
                     time_in = time_ff + TIME_W'(1);
                     if (running_ff && req_pin_level != last_ff) begin
                        if (rec_ff < held) begin
                           cmd.write = 1'b1;
                           rec_in    = rec_ff + CNT_W'(1);
                        end
                        if (rec_in >= held) begin
                           running_in = 1'b0;
                           done_in    = 1'b1;
                        end
                     end
                     last_in = req_pin_level;
                     if (running_in) begin
                        us_in  = us_next;
                        ms_in  = ms_next;
                        sub_in = sub_next;
                        if (tmo_hit) begin
                           running_in = 1'b0;
                           done_in    = 1'b1;
                           tmo_in     = 1'b1;
                        end
                     end
                  end
                  MODE_READ: begin
                     rsp_valid_in = 1'b0;
                     idx_in       = req_entry_index;
                     state_in     = ST_READ;
                  end
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                     rec_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_lvl_ok_in = idx_ext < held;
            rsp_dur_ok_in = idx_next < held;
            rsp_lvl_in    = rsp_lvl_ok_in & rd_level0;
            rsp_dur_in    = rsp_dur_ok_in ? rd_time1 - rd_time0 : '0;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_seq_in  = rec_in - CNT_W'(1);
      rsp_cap_in  = running_in;
      rsp_done_in = done_in;
      rsp_tmo_in  = tmo_in;
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_lvl_ff    <= rsp_lvl_in;
      rsp_lvl_ok_ff <= rsp_lvl_ok_in;
      rsp_dur_ff    <= rsp_dur_in;
      rsp_dur_ok_ff <= rsp_dur_ok_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_cap_ff    <= rsp_cap_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_tmo_ff    <= rsp_tmo_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         pulse_count_ff   <= PULSE_COUNT_RST;
         timeout_value_ff <= TIMEOUT_VALUE_RST;
         timeout_in_us_ff <= 1'b0;
         rec_ff           <= '0;
         time_ff          <= '0;
         us_ff            <= '0;
         ms_ff            <= '0;
         sub_ff           <= '0;
         running_ff       <= 1'b0;
         done_ff          <= 1'b0;
         tmo_ff           <= 1'b0;
         last_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pulse_count_ff   <= pulse_count_in;
         timeout_value_ff <= timeout_value_in;
         timeout_in_us_ff <= timeout_in_us_in;
         rec_ff           <= rec_in;
         time_ff          <= time_in;
         us_ff            <= us_in;
         ms_ff            <= ms_in;
         sub_ff           <= sub_in;
         running_ff       <= running_in;
         done_ff          <= done_in;
         tmo_ff           <= tmo_in;
         last_ff          <= last_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   etcap_store #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (rec_ff),
      .wr_time   (time_in),
      .wr_level  (req_pin_level),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .rd_level0 (rd_level0),
      .rd_time0  (rd_time0),
      .rd_time1  (rd_time1)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_level_at_index   = rsp_lvl_ff;
   assign rsp_level_valid      = rsp_lvl_ok_ff;
   assign rsp_pulse_span       = rsp_dur_ff;
   assign rsp_duration_valid   = rsp_dur_ok_ff;
   assign rsp_sequence_length  = rsp_seq_ff;
   assign rsp_capturing        = rsp_cap_ff;
   assign rsp_completed        = rsp_done_ff;
   assign rsp_timed_out        = rsp_tmo_ff;

endmodule

@@ hw/rtl/etcap_store.sv @@
module etcap_store #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  etcap_pkg::store_cmd_type     cmd,
   input  logic [etcap_pkg::CNT_W-1:0]  wr_addr,
   input  logic [etcap_pkg::TIME_W-1:0] wr_time,
   input  logic                         wr_level,
   input  logic [etcap_pkg::CNT_W-1:0]  rd_addr0,
   input  logic [etcap_pkg::CNT_W-1:0]  rd_addr1,
   output logic                         rd_level0,
   output logic [etcap_pkg::TIME_W-1:0] rd_time0,
   output logic [etcap_pkg::TIME_W-1:0] rd_time1
);
   import etcap_pkg::*;

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int EXT_W = AW + CNT_W;

   // each word: level in the top bit, timestamp below
   logic [TIME_W:0] mem [MAX_ENTRIES];

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [TIME_W:0]  rd_data0_ff, rd_data1_ff;
   logic             rd_ok0_ff, rd_ok1_ff;
   logic [EXT_W-1:0] wr_ext, rd_ext0, rd_ext1;

   assign wr_ext  = EXT_W'(wr_addr);
   assign rd_ext0 = EXT_W'(rd_addr0);
   assign rd_ext1 = EXT_W'(rd_addr1);

   // entries at or above the fill mark read as zero; writes only extend it
   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.write && wr_addr == fill_ff) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[wr_ext[AW-1:0]] <= {wr_level, wr_time};
      end
      rd_data0_ff <= mem[rd_ext0[AW-1:0]];
      rd_data1_ff <= mem[rd_ext1[AW-1:0]];
      rd_ok0_ff   <= rd_addr0 < fill_ff;
      rd_ok1_ff   <= rd_addr1 < fill_ff;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_level0 = rd_ok0_ff & rd_data0_ff[TIME_W];
   assign rd_time0  = rd_ok0_ff ? rd_data0_ff[TIME_W-1:0] : '0;
   assign rd_time1  = rd_ok1_ff ? rd_data1_ff[TIME_W-1:0] : '0;

endmodule

@@ hw/rtl/etcap_checker.sv @@
module etcap_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [etcap_pkg::MODE_W-1:0] req_mode,
   input logic                         rsp_valid,
   input logic                         rsp_level_at_index,
   input logic                         rsp_level_valid,
   input logic [etcap_pkg::TIME_W-1:0] rsp_pulse_span,
   input logic                         rsp_duration_valid,
   input logic                         rsp_capturing,
   input logic                         rsp_completed
);
   import etcap_pkg::*;

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_READ |=> busy && !rsp_valid)
      else $error("read word did not hold off the command channel");

   a_other_word: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode != MODE_READ |=> rsp_valid && !busy)
      else $error("missing word after a non-read command");

   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("read word late");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_valid || !rsp_level_at_index) &&
                    (rsp_duration_valid || rsp_pulse_span == '0) &&
                    (rsp_level_valid || !rsp_duration_valid))
      else $error("invalid read fields not zero");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_capturing && rsp_completed))
      else $error("capture both running and completed");

endmodule

bind edge_timestamp_capture_core etcap_checker u_etcap_checker (.*);

@@ test/edge_capture_checker.sv @@
module edge_capture_checker
   import etcap_pkg::*;
#(
   parameter int MAX_ENTRIES  = 64,
   parameter int TICKS_PER_MS = 1000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic                  req_pin_level,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_valid,
   input  logic                  rsp_level_at_index,
   input  logic                  rsp_level_valid,
   input  logic [TIME_W-1:0]     rsp_pulse_span,
   input  logic                  rsp_duration_valid,
   input  logic [CNT_W-1:0]      rsp_sequence_length,
   input  logic                  rsp_capturing,
   input  logic                  rsp_completed,
   input  logic                  rsp_timed_out,
   output int                    fail_count,
   output int                    words_pending
);

   typedef struct packed {
      logic              level;
      logic              level_ok;
      logic [TIME_W-1:0] duration;
      logic              duration_ok;
      logic [CNT_W-1:0]  seq_len;
      logic              capturing;
      logic              completed;
      logic              by_timeout;
   } capture_word_type;

   capture_word_type  expected_words[$];
   int                mismatches = 0;

   logic [TIME_W-1:0] edge_time_mem [MAX_ENTRIES];
   logic              edge_level_mem[MAX_ENTRIES];
   logic [CNT_W-1:0]  recorded;
   logic [TIME_W-1:0] time_now;
   longint unsigned   elapsed;
   logic              armed;
   logic              done;
   logic              timed_out;
   logic              last_level;
   logic [PC_W-1:0]   pulse_count;
   logic [TMO_W-1:0]  timeout_value;
   logic              timeout_in_us;

   function automatic logic [CNT_W-1:0] entries_held();
      int n;
      n = int'(pulse_count) + 1;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      return CNT_W'(n);
   endfunction

   function automatic void clear_store();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         edge_time_mem[i]  = '0;
         edge_level_mem[i] = 1'b0;
      end
      recorded = '0;
   endfunction

   function automatic void reset_capture();
      clear_store();
      time_now      = '0;
      elapsed       = 0;
      armed         = 1'b0;
      done          = 1'b0;
      timed_out     = 1'b0;
      last_level    = 1'b0;
      pulse_count   = PULSE_COUNT_RST;
      timeout_value = TIMEOUT_VALUE_RST;
      timeout_in_us = 1'b0;
   endfunction

   function automatic capture_word_type advance_capture(mode_type mode, logic pin,
                                                        logic [IDX_W-1:0] idx);
      capture_word_type w;
      logic [CNT_W-1:0] held;
      logic [CNT_W-1:0] nxt;
      longint unsigned  span;
      w    = '0;
      held = entries_held();
      case (mode)
         MODE_START: begin
            recorded  = '0;
            elapsed   = 0;
            armed     = 1'b1;
            done      = 1'b0;
            timed_out = 1'b0;
         end
         MODE_TICK: begin
            time_now = time_now + TIME_W'(1);
            if (armed && pin != last_level) begin
               if (recorded < held) begin
                  edge_time_mem[recorded[IDX_W-1:0]]  = time_now;
                  edge_level_mem[recorded[IDX_W-1:0]] = pin;
                  recorded = recorded + CNT_W'(1);
               end
               if (recorded >= held) begin
                  armed = 1'b0;
                  done  = 1'b1;
               end
            end
            last_level = pin;
            if (armed) begin
               span = timeout_in_us ? 64'(timeout_value)
                                    : 64'(timeout_value) * longint'(TICKS_PER_MS);
               if (elapsed != '1) elapsed++;
               if (elapsed >= span) begin
                  armed     = 1'b0;
                  done      = 1'b1;
                  timed_out = 1'b1;
               end
            end
         end
         MODE_READ: begin
            nxt = {1'b0, idx} + CNT_W'(1);
            if ({1'b0, idx} < held) begin
               w.level_ok = 1'b1;
               w.level    = edge_level_mem[idx];
            end
            if (nxt < held) begin
               w.duration_ok = 1'b1;
               w.duration    = edge_time_mem[nxt[IDX_W-1:0]] - edge_time_mem[idx];
            end
         end
         default: clear_store();
      endcase
      w.seq_len    = recorded - CNT_W'(1);
      w.capturing  = armed;
      w.completed  = done;
      w.by_timeout = timed_out;
      return w;
   endfunction

   task automatic compare_field(string field, logic [TIME_W-1:0] want,
                                logic [TIME_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      capture_word_type want;
      capture_word_type got;
      if (reset) begin
         reset_capture();
         expected_words.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            got = {rsp_level_at_index, rsp_level_valid, rsp_pulse_span,
                   rsp_duration_valid, rsp_sequence_length, rsp_capturing,
                   rsp_completed, rsp_timed_out};
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word with nothing expected: %h", got);
            end else begin
               want = expected_words.pop_front();
               compare_field("level_at_index", TIME_W'(want.level), TIME_W'(got.level));
               compare_field("level_valid", TIME_W'(want.level_ok),
                             TIME_W'(got.level_ok));
               compare_field("pulse_span", want.duration, got.duration);
               compare_field("duration_valid", TIME_W'(want.duration_ok),
                             TIME_W'(got.duration_ok));
               compare_field("sequence_length", TIME_W'(want.seq_len),
                             TIME_W'(got.seq_len));
               compare_field("capturing", TIME_W'(want.capturing),
                             TIME_W'(got.capturing));
               compare_field("completed", TIME_W'(want.completed),
                             TIME_W'(got.completed));
               compare_field("timed_out", TIME_W'(want.by_timeout),
                             TIME_W'(got.by_timeout));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PULSE_COUNT:   pulse_count   = csr_wdata[PC_W-1:0];
               CSR_TIMEOUT_VALUE: timeout_value = csr_wdata[TMO_W-1:0];
               CSR_TIMEOUT_IN_US: timeout_in_us = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && busy === 1'b0)
            expected_words.push_back(advance_capture(mode_type'(req_mode),
                                                     req_pin_level, req_entry_index));
      end
      words_pending <= expected_words.size();
      fail_count    <= mismatches;
   end

endmodule

@@ test/edge_timestamp_capture_core_test.sv @@
module edge_timestamp_capture_core_test;
   import etcap_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [MODE_W-1:0]     req_mode;
   logic                  req_pin_level;
   logic [IDX_W-1:0]      req_entry_index;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_valid;
   logic                  rsp_level_at_index;
   logic                  rsp_level_valid;
   logic [TIME_W-1:0]     rsp_pulse_span;
   logic                  rsp_duration_valid;
   logic signed [CNT_W-1:0] rsp_sequence_length;
   logic                  rsp_capturing;
   logic                  rsp_completed;
   logic                  rsp_timed_out;
   int                    fail_count;
   int                    words_pending;

   int                    words_sent = 0;
   int                    quiet_cycles = 0;
   bit                    steady = 0;
   logic                  pin_now = 1'b0;

   edge_timestamp_capture_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_pin_level       (req_pin_level),
      .req_entry_index     (req_entry_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_level_at_index  (rsp_level_at_index),
      .rsp_level_valid     (rsp_level_valid),
      .rsp_pulse_span      (rsp_pulse_span),
      .rsp_duration_valid  (rsp_duration_valid),
      .rsp_sequence_length (rsp_sequence_length),
      .rsp_capturing       (rsp_capturing),
      .rsp_completed       (rsp_completed),
      .rsp_timed_out       (rsp_timed_out)
   );

   edge_capture_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_pin_level       (req_pin_level),
      .req_entry_index     (req_entry_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_level_at_index  (rsp_level_at_index),
      .rsp_level_valid     (rsp_level_valid),
      .rsp_pulse_span      (rsp_pulse_span),
      .rsp_duration_valid  (rsp_duration_valid),
      .rsp_sequence_length (rsp_sequence_length),
      .rsp_capturing       (rsp_capturing),
      .rsp_completed       (rsp_completed),
      .rsp_timed_out       (rsp_timed_out),
      .fail_count          (fail_count),
      .words_pending       (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic issue(mode_type mode, logic pin, logic [IDX_W-1:0] idx);
      while (!steady && $urandom_range(99) < 29) begin
         start           <= 1'b0;
         req_mode        <= MODE_W'($urandom_range(3));
         req_pin_level   <= 1'($urandom_range(1));
         req_entry_index <= IDX_W'($urandom_range(63));
         @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_pin_level   <= pin;
      req_entry_index <= idx;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (mode == MODE_TICK) pin_now = pin;
      words_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic capture_phase();
      logic [PC_W-1:0]  pc;
      logic [TMO_W-1:0] tv;
      logic             tus;
      int               ticks;
      int               reads;
      settle();
      case ($urandom_range(3))
         0:       pc = '0;
         1:       pc = '1;
         default: pc = PC_W'($urandom_range(1, 12));
      endcase
      tus = 1'($urandom_range(1));
      if (tus) begin
         case ($urandom_range(3))
            0:       tv = '1;
            1:       tv = TMO_W'($urandom_range(1, 4));
            default: tv = TMO_W'($urandom_range(5, 80));
         endcase
      end else begin
         tv = TMO_W'($urandom_range(2, 24'hFFFFFF));
      end
      if ($urandom_range(9) < 7)
         csr_write(CSR_PULSE_COUNT,
                   (CSR_DATA_W'($urandom) & 24'hFFFFC0) | CSR_DATA_W'(pc));
      if ($urandom_range(9) < 7) csr_write(CSR_TIMEOUT_VALUE, tv);
      if ($urandom_range(9) < 7)
         csr_write(CSR_TIMEOUT_IN_US,
                   (CSR_DATA_W'($urandom) & 24'hFFFFFE) | CSR_DATA_W'(tus));
      if ($urandom_range(9) < 8) begin
         issue(MODE_START, 1'($urandom_range(1)), IDX_W'($urandom_range(63)));
         ticks = $urandom_range(1, 2 * int'(pc) + 12);
         repeat (ticks) begin
            if ($urandom_range(9) == 0)
               issue(MODE_READ, 1'($urandom_range(1)), IDX_W'($urandom_range(63)));
            else if ($urandom_range(99) < 55)
               issue(MODE_TICK, ~pin_now, IDX_W'($urandom_range(63)));
            else
               issue(MODE_TICK, pin_now, IDX_W'($urandom_range(63)));
         end
         reads = $urandom_range(1, int'(pc) + 3);
         for (int i = 0; i < reads; i++)
            issue(MODE_READ, 1'($urandom_range(1)), IDX_W'(i > 63 ? 63 : i));
         issue(MODE_READ, 1'($urandom_range(1)), IDX_W'($urandom_range(63)));
         if ($urandom_range(7) == 0) begin
            issue(MODE_CLEAR, 1'($urandom_range(1)), IDX_W'($urandom_range(63)));
            issue(MODE_READ, 1'($urandom_range(1)), IDX_W'($urandom_range(3)));
         end
      end else begin
         repeat ($urandom_range(5, 30))
            issue(mode_type'($urandom_range(3)), 1'($urandom_range(1)),
                  IDX_W'($urandom_range(63)));
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = '0;
      req_pin_level   = 1'b0;
      req_entry_index = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store, pin tracked while not capturing, count ends capture
      issue(MODE_READ, 1'b1, 6'd0);
      issue(MODE_READ, 1'b0, 6'd63);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_READ, 1'b0, 6'd0);
      issue(MODE_READ, 1'b0, 6'd1);
      issue(MODE_READ, 1'b0, 6'd2);
      issue(MODE_CLEAR, 1'b1, 6'd63);
      issue(MODE_READ, 1'b0, 6'd1);

      // single entry held, zero timeout
      settle();
      csr_write(CSR_PULSE_COUNT, 24'hABCDC0);
      csr_write(CSR_TIMEOUT_VALUE, 24'd0);
      csr_write(CSR_TIMEOUT_IN_US, 24'd1);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b0, 6'd0);
      issue(MODE_READ, 1'b0, 6'd0);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b0, 6'd0);

      // restart while running, tick timeout
      settle();
      csr_write(CSR_PULSE_COUNT, 24'd63);
      csr_write(CSR_TIMEOUT_VALUE, 24'd3);
      csr_write(CSR_UNUSED, 24'hFFFFFF);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);

      // count lowered below entries already held
      settle();
      csr_write(CSR_PULSE_COUNT, 24'd5);
      csr_write(CSR_TIMEOUT_VALUE, 24'hFFFFFF);
      issue(MODE_START, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b0, 6'd0);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_TICK, 1'b0, 6'd0);
      settle();
      csr_write(CSR_PULSE_COUNT, 24'd1);
      issue(MODE_TICK, 1'b1, 6'd0);
      issue(MODE_READ, 1'b0, 6'd2);

      while (words_sent < 440) begin
         steady = (words_sent >= 220 && words_sent < 360);
         capture_phase();
      end
      steady = 0;

      // millisecond unit: a count that would time out in ticks keeps running
      settle();
      csr_write(CSR_PULSE_COUNT, CSR_DATA_W'($urandom_range(63)));
      csr_write(CSR_TIMEOUT_VALUE, 24'd1);
      csr_write(CSR_TIMEOUT_IN_US, 24'd0);
      issue(MODE_START, 1'b0, 6'd0);
      repeat (60) issue(MODE_TICK, pin_now, IDX_W'($urandom_range(63)));
      issue(MODE_READ, 1'b0, 6'd0);

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/etcap_pkg.sv
hw/rtl/etcap_store.sv
hw/rtl/edge_timestamp_capture_core.sv
hw/rtl/etcap_checker.sv
test/edge_capture_checker.sv
test/edge_timestamp_capture_core_test.sv
